// ===== rtl/tst_pkg.sv =====
// Shared types and constants for the software timer table.
// Used by tst_engine and software_timer_table_core; no other dependencies.
`timescale 1ns / 1ps

package tst_pkg;

  localparam int TASK_W = 3;
  localparam int TICK_W = 32;
  localparam int OP_W   = 3;

  // Operation codes carried with each request
  typedef enum logic [OP_W-1:0] {
    OP_LOAD       = 3'd0,
    OP_ACTIVATE   = 3'd1,
    OP_DEACTIVATE = 3'd2,
    OP_TICK       = 3'd3,
    OP_DISPATCH   = 3'd4
  } op_e;

  // One decoded request
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TASK_W-1:0] idx;
    logic [TICK_W-1:0] ticks;
    logic              periodic;
  } req_t;

  // One result pushed toward the output register
  typedef struct packed {
    logic              push;
    logic              fired;
    logic [TASK_W-1:0] fired_task;
    logic              last;
  } res_t;

endpackage

// ===== rtl/tst_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps

module tst_ram #(
  parameter int  DEPTH = 8,
  parameter int  WIDTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/tst_engine.sv =====
// Timer table engine: per-entry flags, scan sequencer, count and reload RAMs.
// Depends on tst_pkg and tst_ram.
`timescale 1ns / 1ps

module tst_engine #(
  parameter int NUM_TASKS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  tst_pkg::req_t req_i,
  output logic          ready_o,
  input  logic          out_free_i,
  output tst_pkg::res_t res_o
);
  import tst_pkg::*;

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_DISP,
    S_FLUSH
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   k_q, k_d;
  logic               emitted_q, emitted_d;
  logic               p_vld_q, p_vld_d;
  logic [IDX_W-1:0]   p_idx_q, p_idx_d;
  logic               wb_vld_q, wb_vld_d;
  logic [IDX_W-1:0]   wb_idx_q, wb_idx_d;

  logic [NUM_TASKS-1:0] act_q, act_d;
  logic [NUM_TASKS-1:0] per_q, per_d;
  logic [NUM_TASKS-1:0] exp_q, exp_d;
  logic [NUM_TASKS-1:0] cvld_q, cvld_d;

  logic [IDX_W-1:0]   req_idx;
  logic               in_range;
  logic               load_hit;
  logic               act_hit;
  logic               deact_hit;

  logic [TICK_W-1:0]  cnt_rdata;
  logic [TICK_W-1:0]  rld_rdata;
  logic               cnt_we;
  logic [IDX_W-1:0]   cnt_waddr;
  logic [TICK_W-1:0]  cnt_wdata;

  logic [NUM_TASKS-1:0] fire_vec;
  logic [NUM_TASKS-1:0] hi_mask;
  logic               fire_k;
  logic               k_last;
  logic               need_push;
  logic               stall;
  logic               disp_take;

  logic [TICK_W-1:0]  t_cnt;
  logic               t_go;
  logic [TICK_W-1:0]  t_dec;

  // Decode the request index and kind
  assign req_idx   = IDX_W'(req_i.idx);
  assign in_range  = 32'(req_i.idx) < 32'(NUM_TASKS);
  assign load_hit  = accept_i && in_range && (req_i.op == OP_LOAD);
  assign act_hit   = accept_i && in_range && (req_i.op == OP_ACTIVATE);
  assign deact_hit = accept_i && in_range && (req_i.op == OP_DEACTIVATE);
  assign ready_o   = (state_q == S_IDLE);

  // Dispatch scan: find fired entries and whether any lies above the cursor
  assign fire_vec = act_q & exp_q;
  always_comb begin
    for (int i = 0; i < NUM_TASKS; i++) begin
      hi_mask[i] = (IDX_W'(i) > k_q);
    end
  end
  assign fire_k    = fire_vec[k_q];
  assign k_last    = (k_q == IDX_W'(NUM_TASKS - 1));
  assign need_push = (state_q == S_DISP) && (fire_k || (k_last && !emitted_q));
  assign stall     = need_push && !out_free_i;
  assign disp_take = (state_q == S_DISP) && fire_k && out_free_i;

  always_comb begin
    res_o.push       = need_push && out_free_i;
    res_o.fired      = fire_k;
    res_o.fired_task = fire_k ? TASK_W'(k_q) : '0;
    res_o.last       = fire_k ? !(|(fire_vec & hi_mask)) : 1'b1;
  end

  // Tick stage two: count down the entry read last cycle
  assign t_cnt = cvld_q[p_idx_q] ? cnt_rdata : '0;
  assign t_go  = p_vld_q && act_q[p_idx_q] && !exp_q[p_idx_q] && (t_cnt != '0);
  assign t_dec = t_cnt - 1'b1;

  // Count RAM write port: load, tick writeback or periodic reload
  always_comb begin
    cnt_we    = load_hit || t_go || wb_vld_q;
    cnt_waddr = req_idx;
    cnt_wdata = req_i.ticks;
    if (t_go) begin
      cnt_waddr = p_idx_q;
      cnt_wdata = t_dec;
    end else if (wb_vld_q) begin
      cnt_waddr = wb_idx_q;
      cnt_wdata = rld_rdata;
    end
  end

  tst_ram #(
    .DEPTH (NUM_TASKS),
    .WIDTH (TICK_W)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (k_q),
    .rdata_o (cnt_rdata)
  );

  tst_ram #(
    .DEPTH (NUM_TASKS),
    .WIDTH (TICK_W)
  ) u_rld_ram (
    .clk_i   (clk_i),
    .we_i    (load_hit),
    .waddr_i (req_idx),
    .wdata_i (req_i.ticks),
    .raddr_i (k_q),
    .rdata_o (rld_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    emitted_d = emitted_q;
    p_vld_d   = 1'b0;
    p_idx_d   = p_idx_q;
    wb_vld_d  = 1'b0;
    wb_idx_d  = wb_idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_i && (req_i.op == OP_TICK)) begin
          state_d = S_TICK;
          k_d     = '0;
        end else if (accept_i && (req_i.op == OP_DISPATCH)) begin
          state_d   = S_DISP;
          k_d       = '0;
          emitted_d = 1'b0;
        end
      end
      S_TICK: begin
        p_vld_d = 1'b1;
        p_idx_d = k_q;
        if (k_last) begin
          state_d = S_FLUSH;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_DISP: begin
        if (!stall) begin
          if (fire_k) begin
            emitted_d = 1'b1;
            wb_vld_d  = per_q[k_q];
            wb_idx_d  = k_q;
          end
          if (k_last) begin
            state_d = S_FLUSH;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      k_q       <= '0;
      emitted_q <= 1'b0;
      p_vld_q   <= 1'b0;
      p_idx_q   <= '0;
      wb_vld_q  <= 1'b0;
      wb_idx_q  <= '0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      emitted_q <= emitted_d;
      p_vld_q   <= p_vld_d;
      p_idx_q   <= p_idx_d;
      wb_vld_q  <= wb_vld_d;
      wb_idx_q  <= wb_idx_d;
    end
  end

  // Per-entry flag updates
  always_comb begin
    act_d  = act_q;
    per_d  = per_q;
    exp_d  = exp_q;
    cvld_d = cvld_q;
    if (load_hit) begin
      act_d[req_idx]  = 1'b1;
      per_d[req_idx]  = req_i.periodic;
      exp_d[req_idx]  = 1'b0;
      cvld_d[req_idx] = 1'b1;
    end
    if (act_hit) begin
      act_d[req_idx] = 1'b1;
    end
    if (deact_hit) begin
      act_d[req_idx] = 1'b0;
    end
    if (t_go && (t_dec == '0)) begin
      exp_d[p_idx_q] = 1'b1;
    end
    if (disp_take) begin
      exp_d[k_q] = 1'b0;
      act_d[k_q] = per_q[k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= '0;
      per_q  <= '0;
      exp_q  <= '0;
      cvld_q <= '0;
    end else begin
      act_q  <= act_d;
      per_q  <= per_d;
      exp_q  <= exp_d;
      cvld_q <= cvld_d;
    end
  end

  // Only a loaded entry can be expired
  a_exp_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q & ~cvld_q) == '0)
    else $error("expired entry without a loaded count");

  // A result is pushed only into a free output slot during a dispatch scan
  a_push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.push |-> (out_free_i && (state_q == S_DISP)))
    else $error("result pushed outside dispatch or into a full slot");

  // Tick writeback and reload writeback never compete for the count RAM
  a_one_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(p_vld_q && wb_vld_q))
    else $error("two count writebacks in one cycle");

  // A dispatch that fires nothing ends with exactly one empty result
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.push && !res_o.fired) |-> (res_o.last && k_last && !emitted_q))
    else $error("empty result not at end of scan");

endmodule

// ===== rtl/software_timer_table_core.sv =====
// Top level of the software timer table: stream ports and output register.
// Depends on tst_pkg and tst_engine.
//
//   channel   dir  tuser           tdata                                        tlast
//   s_axis    in   op [2:0]        task_req[2:0] load_ticks[34:3] keep[35]     -
//   m_axis    out  fired [0]       fired_task[2:0]                              last
//
// Load, activate, deactivate and unknown ops are handled without leaving idle.
// For tick and dispatch the sequencer walks the table one entry per cycle, except
// while a dispatch holds, through the synchronous count and reload RAMs, then drains.
// A dispatch holds on any entry with a result to push, including the closing
// empty result, while the output register is full and not being taken.
// Reset clears all entry flags; the RAMs need no clearing pass.
`timescale 1ns / 1ps

module software_timer_table_core #(
  parameter int NUM_TASKS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // task_req[2:0], load_ticks[34:3], keep_active[35]
  input  logic [2:0]  s_axis_tuser,   // op[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // fired_task[2:0]
  output logic [0:0]  m_axis_tuser,   // fired[0]
  output logic        m_axis_tlast    // last
);
  import tst_pkg::*;

  req_t              req;
  res_t              res;
  logic              accept;
  logic              out_free;

  logic              m_vld_q, m_vld_d;
  logic              m_fired_q, m_fired_d;
  logic [TASK_W-1:0] m_task_q, m_task_d;
  logic              m_last_q, m_last_d;

  // Unpack the request
  always_comb begin
    req.op       = s_axis_tuser;
    req.idx      = s_axis_tdata[2:0];
    req.ticks    = s_axis_tdata[34:3];
    req.periodic = s_axis_tdata[35];
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  tst_engine #(
    .NUM_TASKS (NUM_TASKS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (req),
    .ready_o    (s_axis_tready),
    .out_free_i (out_free),
    .res_o      (res)
  );

  // Output register: load on push, drop when taken
  assign out_free = !m_vld_q || m_axis_tready;

  always_comb begin
    m_vld_d   = m_vld_q;
    m_fired_d = m_fired_q;
    m_task_d  = m_task_q;
    m_last_d  = m_last_q;
    if (res.push) begin
      m_vld_d   = 1'b1;
      m_fired_d = res.fired;
      m_task_d  = res.fired_task;
      m_last_d  = res.last;
    end else if (m_axis_tready) begin
      m_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_fired_q <= m_fired_d;
    m_task_q  <= m_task_d;
    m_last_q  <= m_last_d;
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {5'b0, m_task_q};
  assign m_axis_tuser  = m_fired_q;
  assign m_axis_tlast  = m_last_q;

endmodule
